/* rtl/core/nsti_pkg.sv */
// ----------------------------------------------------------------------------
// nsti_pkg: shared types and constants of the score table block
// sizes of the tables, slot entry layout and the write request to the store
// ----------------------------------------------------------------------------
package nsti_pkg;

    localparam int ENTRIES  = 10;
    localparam int TABLES   = 3;
    localparam int DEPTH    = ENTRIES * TABLES;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int SEL_W    = 2;
    localparam int SCORE_W  = 16;
    localparam int TAG_W    = 64;
    localparam int RANK_W   = 4;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 88;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } wr_req_t;

    // first store address of a table
    function automatic addr_t table_base(input logic [SEL_W-1:0] sel);
        return ADDR_W'(int'(sel) * ENTRIES);
    endfunction

endpackage

/* rtl/core/top_n_score_table_insert.sv */
// ----------------------------------------------------------------------------
// top_n_score_table_insert: sorted top-n score tables with insert and dump
// keeps several ascending score tables in one slot memory, inserts a new
// entry in one read-modify-write pass and streams the whole table out
// ----------------------------------------------------------------------------
// first slot item passes ST_FIRST, ST_EMIT and the output register, then one slot per cycle
// s_ takes no new item until the pass is over (accept, first read, ten slots),
//   since the single read port of the slot memory is walked one slot a cycle
// an item naming a missing table is taken in ST_IDLE and gives no output
// backpressure on m_ stretches the pass by the stalled cycles
// reset: synchronous, active low; all tables read as zero afterwards
module top_n_score_table_insert (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nsti_pkg::S_DATA_W-1:0]  s_tdata,  // entry_score[15:0], entry_tag[79:16]
    input  logic [nsti_pkg::SEL_W-1:0]     s_tuser,  // table_select[1:0]
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nsti_pkg::M_DATA_W-1:0]  m_tdata,  // rank_position[3:0], slot_score[19:4],
                                                     // slot_tag[83:20], zero pad[87:84]
    output logic                           m_tlast   // last_slot
);
    import nsti_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    addr_t                 base_reg;
    logic [SCORE_W-1:0]    score_reg;
    logic [TAG_W-1:0]      tag_reg;
    idx_t                  k_reg;        // slot being emitted
    idx_t                  idx_reg;      // slot held in the memory read register
    entry_t                hold_reg;     // old contents of slot k
    logic                  shift_reg;    // new entry still moving up
    logic                  out_valid_reg;
    logic [RANK_W-1:0]     out_rank_reg;
    entry_t                out_entry_reg;
    logic                  out_last_reg;

    logic [SEL_W-1:0]      s_sel;
    logic [SCORE_W-1:0]    s_score;
    logic [TAG_W-1:0]      s_tag;
    logic                  sel_ok;
    logic                  accept;
    logic                  out_free;
    logic                  advance;
    logic                  last_k;
    logic                  move_up;
    logic                  place;
    idx_t                  idx_next;
    entry_t                step_entry;
    entry_t                rd_data;
    addr_t                 rd_addr;
    wr_req_t               wr;

    // unpack the input item
    assign s_sel   = s_tuser;
    assign s_score = s_tdata[SCORE_W-1:0];
    assign s_tag   = s_tdata[SCORE_W+TAG_W-1:SCORE_W];
    assign sel_ok  = int'(s_sel) < TABLES;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // output register frees up when empty or being taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = (state_reg == ST_EMIT) && out_free;
    assign last_k   = (k_reg == IDX_W'(ENTRIES - 1));

    // memory read register holds slot k+1 while k is not the last slot
    assign move_up  = shift_reg && !last_k && (rd_data.score < score_reg);
    assign place    = shift_reg && !move_up;

    // slot k after the insert: shifted-down neighbour, the new entry or unchanged
    always_comb begin
        if (move_up) begin
            step_entry = rd_data;
        end else if (place) begin
            step_entry = '{score: score_reg, tag: tag_reg};
        end else begin
            step_entry = hold_reg;
        end
    end

    // only slots up to the new entry's final place are rewritten
    assign wr.en   = advance && shift_reg;
    assign wr.addr = base_reg + ADDR_W'(k_reg);
    assign wr.data = step_entry;

    // read address runs one slot ahead of the emitted slot, clamped to the table
    assign idx_next = (advance && (idx_reg != IDX_W'(ENTRIES - 1))) ? idx_reg + 1'b1 : idx_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE:  rd_addr = sel_ok ? table_base(s_sel) : '0;
            ST_FIRST: rd_addr = base_reg + ADDR_W'(1);
            ST_EMIT:  rd_addr = base_reg + ADDR_W'(idx_next);
            default:  rd_addr = '0;
        endcase
    end

    nsti_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && sel_ok) begin
                        base_reg  <= table_base(s_sel);
                        score_reg <= s_score;
                        tag_reg   <= s_tag;
                        state_reg <= ST_FIRST;
                    end
                end
                ST_FIRST: begin
                    // lowest slot decides whether the entry goes in at all
                    hold_reg  <= rd_data;
                    shift_reg <= score_reg > rd_data.score;
                    idx_reg   <= IDX_W'(1);
                    k_reg     <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (advance) begin
                        hold_reg <= rd_data;
                        idx_reg  <= idx_next;
                        k_reg    <= k_reg + 1'b1;
                        if (place) begin
                            shift_reg <= 1'b0;
                        end
                        if (last_k) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (advance) begin
                out_valid_reg <= 1'b1;
                out_rank_reg  <= RANK_W'(k_reg);
                out_entry_reg <= step_entry;
                out_last_reg  <= last_k;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RANK_W - SCORE_W - TAG_W){1'b0}},
                       out_entry_reg.tag, out_entry_reg.score, out_rank_reg};
    assign m_tlast  = out_last_reg;

    // checks
    a_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (out_rank_reg == RANK_W'(ENTRIES - 1)))
        else $error("last slot item with wrong rank");

    a_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == ST_EMIT && out_free))
        else $error("slot write outside the emit pass");

    a_valid_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && sel_ok) |=> (state_reg == ST_FIRST))
        else $error("accepted item did not start a pass");

    a_bad_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !sel_ok) |=> (state_reg == ST_IDLE && !wr.en))
        else $error("item for a missing table started a pass");

    a_read_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !last_k) |-> (idx_reg == k_reg + 1'b1))
        else $error("read slot not one ahead of emitted slot");

endmodule

/* rtl/core/nsti_store.sv */
// ----------------------------------------------------------------------------
// nsti_store: slot memory of all score tables
// one write port and one registered read port, unwritten slots read as zero
// ----------------------------------------------------------------------------
module nsti_store (
    input  logic            aclk,
    input  logic            aresetn,
    input  nsti_pkg::wr_req_t wr,
    input  nsti_pkg::addr_t rd_addr,
    output nsti_pkg::entry_t rd_data
);
    import nsti_pkg::*;

    entry_t           mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    entry_t           rd_data_reg;

    // per-slot valid flags give the all-zero reset contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the top-n score table block
// drives insert items on the s_ stream and checks every slot item on the m_
// stream against an in-bench model of the three sorted tables. directed
// corner cases come first, then random inserts under several idle and
// stall mixes
// ----------------------------------------------------------------------------
module tb_top;

    import nsti_pkg::*;

    // table codes carried in s_tuser; the last one names no table
    typedef enum logic [SEL_W-1:0] {
        TABLE_EASY   = 2'd0,
        TABLE_MEDIUM = 2'd1,
        TABLE_HARD   = 2'd2,
        TABLE_NONE   = 2'd3
    } table_e;

    // one expected slot item as the block should emit it
    typedef struct {
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } slot_item_t;

    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 30;    // settle time after the last slot item
    localparam int PHASE_ITEMS  = 100;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of every table, works out the slot items
    // each insert should produce and checks the m_ stream against them
    // ------------------------------------------------------------------------
    class score_table_sb;
        logic [SCORE_W-1:0] score_tab [TABLES][ENTRIES];
        logic [TAG_W-1:0]   tag_tab   [TABLES][ENTRIES];
        slot_item_t         slots_due [$];
        int                 mismatches;

        function new();
            for (int t = 0; t < TABLES; t++) begin
                for (int k = 0; k < ENTRIES; k++) begin
                    score_tab[t][k] = '0;
                    tag_tab[t][k]   = '0;
                end
            end
            mismatches = 0;
        endfunction

        function int pending();
            return slots_due.size();
        endfunction

        // sorted insert of one accepted item, then queue the whole table
        function void note_entry(logic [SEL_W-1:0] sel, logic [SCORE_W-1:0] score,
                                 logic [TAG_W-1:0] tag);
            int         pos;
            int         t;
            slot_item_t s;
            if (int'(sel) >= TABLES)
                return;
            t = int'(sel);
            // only a score strictly above the current minimum gets in
            if (score > score_tab[t][0]) begin
                pos = 0;
                // bubble up past strictly smaller scores, ties stay above
                while (pos + 1 < ENTRIES && score_tab[t][pos+1] < score) begin
                    score_tab[t][pos] = score_tab[t][pos+1];
                    tag_tab[t][pos]   = tag_tab[t][pos+1];
                    pos++;
                end
                score_tab[t][pos] = score;
                tag_tab[t][pos]   = tag;
            end
            for (int k = 0; k < ENTRIES; k++) begin
                s.rank  = RANK_W'(k);
                s.score = score_tab[t][k];
                s.tag   = tag_tab[t][k];
                s.last  = (k == ENTRIES - 1);
                slots_due.push_back(s);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_slot(logic [M_DATA_W-1:0] data, logic last);
            slot_item_t want;
            if (slots_due.size() == 0) begin
                report_mismatch($sformatf("slot item with nothing due, tdata %h", data));
                return;
            end
            want = slots_due.pop_front();
            if (data[3:0] !== want.rank)
                report_mismatch($sformatf("rank %0d, want %0d", data[3:0], want.rank));
            if (data[19:4] !== want.score)
                report_mismatch($sformatf("rank %0d score %h, want %h",
                                          want.rank, data[19:4], want.score));
            if (data[83:20] !== want.tag)
                report_mismatch($sformatf("rank %0d tag %h, want %h",
                                          want.rank, data[83:20], want.tag));
            if (data[87:84] !== 4'd0)
                report_mismatch($sformatf("rank %0d pad bits %b", want.rank, data[87:84]));
            if (last !== want.last)
                report_mismatch($sformatf("rank %0d tlast %b, want %b",
                                          want.rank, last, want.last));
        endtask
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [SEL_W-1:0]    s_tuser  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    score_table_sb sb;
    int            idle_pct  = 0;   // chance per cycle that the sender holds off
    int            stall_pct = 0;   // chance per cycle that the receiver stalls
    int            quiet_cycles = 0;

    top_n_score_table_insert DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // entry_score[15:0], entry_tag[79:16]
        .s_tuser  (s_tuser),   // table_select[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // rank_position[3:0], slot_score[19:4], slot_tag[83:20], pad
        .m_tlast  (m_tlast)    // last_slot
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // inputs only move at the rising edge, so the falling edge sees exactly
    // what the next rising edge will accept; all checking is done here
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_slot(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_entry(s_tuser, s_tdata[15:0], s_tdata[79:16]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // watchdog: nothing has moved for far too long
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("top_n_score_table_insert regression: fail");
                $finish;
            end
        end
    end

    // present one insert item and hold it until taken; entered and left on
    // a rising edge so that a back-to-back item keeps tvalid high throughout
    task send_entry(input table_e sel, input logic [SCORE_W-1:0] score,
                    input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sel;
        s_tdata  <= {tag, score};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // random insert: mostly valid tables, scores mixed so that low ties,
    // mid-range inserts and crowding at the top all show up
    task send_random_entry();
        table_e             sel;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        if ($urandom_range(15) == 0)
            sel = TABLE_NONE;
        else
            sel = table_e'($urandom_range(2));
        case ($urandom_range(3))
            0: score = SCORE_W'($urandom_range(31));
            1: score = SCORE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            2: score = SCORE_W'($urandom_range(200, 999));
            default: score = SCORE_W'($urandom);
        endcase
        tag = {$urandom, $urandom};
        send_entry(sel, score, tag);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table code out of range: nothing stored, nothing emitted
        send_entry(TABLE_NONE, 16'hFFFF, {TAG_W{1'b1}});
        send_entry(TABLE_NONE, 16'h0000, 64'h0);
        // empty table: a zero score equals the minimum and is turned away
        send_entry(TABLE_EASY, 16'h0000, 64'h0123_4567_89AB_CDEF);
        send_entry(TABLE_EASY, 16'h0001, 64'hAAAA_AAAA_AAAA_AAAA);
        send_entry(TABLE_EASY, 16'hFFFF, {TAG_W{1'b1}});
        // tie with an existing score lands just below it
        send_entry(TABLE_EASY, 16'h0001, 64'h5555_5555_5555_5555);
        send_entry(TABLE_EASY, 16'h8000, 64'h8000_0000_0000_0001);
        send_entry(TABLE_MEDIUM, 16'hFFFF, 64'h0);
        send_entry(TABLE_MEDIUM, 16'h0001, {TAG_W{1'b1}});
        // fill the hard table completely, arriving in descending order
        for (int k = 19; k >= 10; k--)
            send_entry(TABLE_HARD, SCORE_W'(k), {32'hC0DE_0000 + k, $urandom});
        // full table: score equal to the minimum, below it, and a mid tie
        send_entry(TABLE_HARD, 16'd10, 64'hDEAD_BEEF_0000_0010);
        send_entry(TABLE_HARD, 16'd9, 64'hDEAD_BEEF_0000_0009);
        send_entry(TABLE_HARD, 16'd15, 64'hDEAD_BEEF_0000_0015);

        // random part: no idling, sender gaps, receiver stalls, then both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            repeat (PHASE_ITEMS) send_random_entry();
        end
        s_tvalid <= 1'b0;

        // drain every outstanding slot item, then watch for stray output
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("top_n_score_table_insert regression: pass");
        else
            $display("top_n_score_table_insert regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/nsti_pkg.sv
rtl/core/nsti_store.sv
rtl/core/top_n_score_table_insert.sv
verif/tb_top.sv
